// File: hw/rtl/cebin_pkg.sv
package cebin_pkg;

  localparam int TABLE_LAYERS = 6;
  localparam int IDX_W        = 10;
  localparam int DIV_W        = 40;
  localparam int DVS_W        = 24;
  localparam int VAL_W        = 24;

  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_CELL  = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  localparam logic [5:0] LAYER_CODE [8] = '{6'd1, 6'd2, 6'd3, 6'd12, 6'd13, 6'd14, 6'd0, 6'd0};
  localparam logic [2:0] ETA_LOG    [8] = '{3'd7, 3'd4, 3'd3, 3'd2, 3'd2, 3'd1, 3'd0, 3'd0};
  localparam logic [2:0] PHI_LOG    [8] = '{3'd2, 3'd4, 3'd4, 3'd2, 3'd2, 3'd2, 3'd0, 3'd0};
  localparam logic [IDX_W-1:0] LAYER_BASE [8] = '{10'd0, 10'd512, 10'd768, 10'd896,
                                                  10'd912, 10'd928, 10'd0, 10'd0};

  localparam logic signed [VAL_W-1:0] VAL_MAX = 24'sh7FFFFF;
  localparam logic signed [VAL_W-1:0] VAL_MIN = -24'sh800000;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

endpackage

// File: hw/rtl/cebin_div.sv
module cebin_div
  import cebin_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  div_req_t         req,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W:0]   shifted;
  logic [DVS_W+1:0] trial;

  assign shifted = {rem, quotient[DIV_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIV_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // one quotient bit per cycle, restoring
  always_ff @(posedge clk) begin
    if (req.start) begin
      quotient <= req.dividend;
      rem      <= '0;
      dvs      <= req.divisor;
    end else if (busy) begin
      if (trial[DVS_W+1]) begin
        rem <= shifted[DVS_W-1:0];
      end else begin
        rem <= trial[DVS_W-1:0];
      end
      quotient <= {quotient[DIV_W-2:0], ~trial[DVS_W+1]};
    end
  end

endmodule

// File: hw/rtl/cebin_store.sv
module cebin_store
  import cebin_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic [AW-1:0]           waddr,
  input  logic signed [VAL_W-1:0] wdata,
  input  logic [AW-1:0]           raddr,
  output logic signed [VAL_W-1:0] rdata
);

  logic signed [VAL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/cell_energy_image_binner.sv
// Cell energy image binner: accumulates cluster cell energy fractions into
// six per-layer images held in one on-chip store.
// Input channel s_*: one request per item. Mode 0 starts a cluster, mode 1
// adds one cell, mode 2 reads one bin. Every request gives one result on m_*.
// Configuration: cfg_we/cfg_index/cfg_data write eta_window (0) and
// phi_window (1); write them only while the block is idle.
// One request at a time. A single shared 40-step restoring divider does all
// divisions, one quotient bit per cycle; each division holds the sequencer
// until it is done.
//   mode 1 cell in the window: 3 divisions (eta bin, phi bin, fraction) plus
//     store read; with zero cluster energy the fraction is skipped. A rejected
//     cell or mode 3 gives its result from the check state.
//   mode 2 read: check, then store read.
//   mode 0: a clearing pass over all IMAGE_STORE_DEPTH entries, one entry a cycle.
// Reset runs the same clearing pass with s_tready low; windows return to 1638,
// centre and cluster energy to zero.
// The result waits in an output register while m_tready is low; the next
// request is taken once that register is free or being emptied.
module cell_energy_image_binner
  import cebin_pkg::*;
#(
  parameter int IMAGE_STORE_DEPTH = 1024,
  parameter int NUM_LAYERS        = 6
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // layer_code, position_eta, position_phi, energy, read_layer,
  // read_eta_bin, read_phi_bin
  input  logic [79:0] s_tdata,
  // mode
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // hit_layer, hit_eta_bin, hit_phi_bin, bin_value
  output logic [39:0] m_tdata,
  // accepted, saturated, zero_energy
  output logic [2:0]  m_tuser,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [14:0] cfg_data
);

  localparam int AW = $clog2(IMAGE_STORE_DEPTH);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLEAR = 4'd1;
  localparam logic [3:0] S_CHECK = 4'd2;
  localparam logic [3:0] S_DIVE  = 4'd3;
  localparam logic [3:0] S_DIVP  = 4'd4;
  localparam logic [3:0] S_READ  = 4'd5;
  localparam logic [3:0] S_RWAIT = 4'd6;
  localparam logic [3:0] S_DIVQ  = 4'd7;

  logic [3:0] state;
  logic [AW-1:0] clr_cnt;
  logic clr_reply;

  logic [14:0] eta_window, phi_window;
  logic signed [15:0] centre_eta, centre_phi;
  logic signed [23:0] cluster_energy;

  logic [1:0]  mode_r;
  logic [5:0]  lc_r;
  logic signed [15:0] peta_r, pphi_r;
  logic signed [23:0] e_r;
  logic [2:0]  rl_r;
  logic [6:0]  re_r;
  logic [3:0]  rp_r;

  logic [2:0]  lay_r;
  logic [16:0] nump_r;
  logic [6:0]  be_r;
  logic [IDX_W-1:0] idx_r;

  logic [2:0]  o_layer;
  logic [6:0]  o_eta;
  logic [3:0]  o_phi;
  logic signed [23:0] o_val;
  logic o_acc, o_sat, o_zero;

  div_req_t dreq;
  logic div_done;
  logic [DIV_W-1:0] quot;

  logic st_we;
  logic [AW-1:0] st_waddr;
  logic signed [VAL_W-1:0] st_wdata, st_rdata;

  // lookup, window checks, bin indices and saturating accumulate
  logic found;
  logic [2:0] lay;
  logic [14:0] weta, wphi;
  logic signed [16:0] de, dp;
  logic signed [18:0] nume, nump;
  logic in_e, in_p;
  logic rd_ok;
  logic [IDX_W-1:0] rd_idx, cell_idx;
  logic [23:0] ae, ac;
  logic qneg;
  logic signed [41:0] qs, sum;
  logic signed [23:0] clipped;
  logic sat;

  always_comb begin
    found = 1'b0;
    lay   = '0;
    for (int i = 0; i < TABLE_LAYERS; i++) begin
      if (!found && i < NUM_LAYERS && lc_r == LAYER_CODE[i]) begin
        found = 1'b1;
        lay   = 3'(i);
      end
    end
    weta = (eta_window == '0) ? 15'd1 : eta_window;
    wphi = (phi_window == '0) ? 15'd1 : phi_window;
    de   = {peta_r[15], peta_r} - {centre_eta[15], centre_eta};
    dp   = {pphi_r[15], pphi_r} - {centre_phi[15], centre_phi};
    nume = $signed({de[16], de, 1'b0}) + $signed({4'b0, weta});
    nump = $signed({dp[16], dp, 1'b0}) + $signed({4'b0, wphi});
    in_e = !nume[18] && (nume < $signed({3'b0, weta, 1'b0}));
    in_p = !nump[18] && (nump < $signed({3'b0, wphi, 1'b0}));

    rd_ok  = (int'(rl_r) < TABLE_LAYERS) && (int'(rl_r) < NUM_LAYERS) &&
             ({1'b0, re_r} < (8'd1 << ETA_LOG[rl_r])) &&
             ({1'b0, rp_r} < (5'd1 << PHI_LOG[rl_r]));
    rd_idx = LAYER_BASE[rl_r] + (IDX_W'(re_r) << PHI_LOG[rl_r]) + IDX_W'(rp_r);
    cell_idx = LAYER_BASE[lay_r] + (IDX_W'(be_r) << PHI_LOG[lay_r]) + IDX_W'(quot[3:0]);

    ae   = e_r[23] ? (~e_r + 24'd1) : e_r;
    ac   = cluster_energy[23] ? (~cluster_energy + 24'd1) : cluster_energy;
    qneg = e_r[23] ^ cluster_energy[23];
    qs   = qneg ? -$signed({2'b00, quot}) : $signed({2'b00, quot});
    sum  = qs + 42'(st_rdata);
    sat  = 1'b0;
    if (sum > 42'(VAL_MAX)) begin
      clipped = VAL_MAX;
      sat     = 1'b1;
    end else if (sum < 42'(VAL_MIN)) begin
      clipped = VAL_MIN;
      sat     = 1'b1;
    end else begin
      clipped = sum[23:0];
    end
  end

  always_comb begin
    dreq = '0;
    case (state)
      S_CHECK: begin
        dreq.start    = (mode_r == MODE_CELL) && found && in_e && in_p;
        dreq.dividend = DIV_W'(nume[16:0]) << ETA_LOG[lay];
        dreq.divisor  = DVS_W'({weta, 1'b0});
      end
      S_DIVE: begin
        dreq.start    = div_done;
        dreq.dividend = DIV_W'(nump_r) << PHI_LOG[lay_r];
        dreq.divisor  = DVS_W'({wphi, 1'b0});
      end
      S_RWAIT: begin
        dreq.start    = (mode_r == MODE_CELL) && (cluster_energy != '0);
        dreq.dividend = {ae, 16'b0} + DIV_W'(ac[23:1]);
        dreq.divisor  = ac;
      end
      default: dreq = '0;
    endcase
  end

  always_comb begin
    st_we    = 1'b0;
    st_waddr = clr_cnt;
    st_wdata = '0;
    if (state == S_CLEAR) begin
      st_we = 1'b1;
    end else if (state == S_DIVQ && div_done) begin
      st_we    = 1'b1;
      st_waddr = AW'(idx_r);
      st_wdata = clipped;
    end
  end

  assign s_tready = (state == S_IDLE) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      clr_cnt        <= '0;
      clr_reply      <= 1'b0;
      m_tvalid       <= 1'b0;
      eta_window     <= 15'd1638;
      phi_window     <= 15'd1638;
      centre_eta     <= '0;
      centre_phi     <= '0;
      cluster_energy <= '0;
    end else begin
      // a result only completes while the output register is empty
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_we) begin
        if (cfg_index) begin
          phi_window <= cfg_data;
        end else begin
          eta_window <= cfg_data;
        end
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid && s_tready) begin
            if (s_tuser == MODE_START) begin
              centre_eta     <= s_tdata[21:6];
              centre_phi     <= s_tdata[37:22];
              cluster_energy <= s_tdata[61:38];
              clr_cnt        <= '0;
              clr_reply      <= 1'b1;
              state          <= S_CLEAR;
            end else begin
              state <= S_CHECK;
            end
          end
        end
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == AW'(IMAGE_STORE_DEPTH - 1)) begin
            state <= S_IDLE;
            if (clr_reply) begin
              m_tvalid <= 1'b1;
            end
            clr_reply <= 1'b0;
          end
        end
        S_CHECK: begin
          if (mode_r == MODE_CELL && found && in_e && in_p) begin
            state <= S_DIVE;
          end else if (mode_r == MODE_READ && rd_ok &&
                       int'(rd_idx) < IMAGE_STORE_DEPTH) begin
            state <= S_READ;
          end else begin
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        S_DIVE: begin
          if (div_done) begin
            state <= S_DIVP;
          end
        end
        S_DIVP: begin
          if (div_done) begin
            if (int'(cell_idx) < IMAGE_STORE_DEPTH) begin
              state <= S_READ;
            end else begin
              m_tvalid <= 1'b1;
              state    <= S_IDLE;
            end
          end
        end
        S_READ: begin
          state <= S_RWAIT;
        end
        S_RWAIT: begin
          if (mode_r == MODE_CELL && cluster_energy != '0) begin
            state <= S_DIVQ;
          end else begin
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        S_DIVQ: begin
          if (div_done) begin
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // request fields, working values and result payload
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      mode_r <= s_tuser;
      lc_r   <= s_tdata[5:0];
      peta_r <= s_tdata[21:6];
      pphi_r <= s_tdata[37:22];
      e_r    <= s_tdata[61:38];
      rl_r   <= s_tdata[64:62];
      re_r   <= s_tdata[71:65];
      rp_r   <= s_tdata[75:72];
      o_layer <= '0;
      o_eta   <= '0;
      o_phi   <= '0;
      o_val   <= '0;
      o_acc   <= 1'b0;
      o_sat   <= 1'b0;
      o_zero  <= 1'b0;
    end
    case (state)
      S_CHECK: begin
        lay_r  <= lay;
        nump_r <= nump[16:0];
        idx_r  <= rd_idx;
        if (mode_r == MODE_READ && rd_ok && int'(rd_idx) < IMAGE_STORE_DEPTH) begin
          o_layer <= rl_r;
          o_eta   <= re_r;
          o_phi   <= rp_r;
        end
      end
      S_DIVE: begin
        if (div_done) begin
          be_r <= quot[6:0];
        end
      end
      S_DIVP: begin
        if (div_done) begin
          idx_r <= cell_idx;
          if (int'(cell_idx) < IMAGE_STORE_DEPTH) begin
            o_layer <= lay_r;
            o_eta   <= be_r;
            o_phi   <= quot[3:0];
          end
        end
      end
      S_RWAIT: begin
        if (mode_r == MODE_READ) begin
          o_val <= st_rdata;
        end else if (cluster_energy == '0) begin
          o_val  <= st_rdata;
          o_zero <= 1'b1;
        end
      end
      S_DIVQ: begin
        if (div_done) begin
          o_val <= clipped;
          o_sat <= sat;
          o_acc <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign m_tdata = {2'b00, o_val, o_phi, o_eta, o_layer};
  assign m_tuser = {o_zero, o_sat, o_acc};

  cebin_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (dreq),
    .done     (div_done),
    .quotient (quot)
  );

  cebin_store #(
    .DEPTH (IMAGE_STORE_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (AW'(idx_r)),
    .rdata (st_rdata)
  );

endmodule

// File: test/cell_energy_image_binner_tb.sv
`timescale 1ns / 1ps

module cell_energy_image_binner_tb;
  import cebin_pkg::*;

  localparam logic [1:0] MODE_IDLE = 2'd3;
  localparam logic CFG_ETA_WINDOW = 1'b0;
  localparam logic CFG_PHI_WINDOW = 1'b1;
  localparam int STORE_DEPTH = 1024;
  localparam int N_LAYERS = 6;

  typedef struct packed {
    logic [1:0]         mode;
    logic [5:0]         code;
    logic signed [15:0] eta;
    logic signed [15:0] phi;
    logic signed [23:0] energy;
    logic [2:0]         rlayer;
    logic [6:0]         reta;
    logic [3:0]         rphi;
  } cell_req_t;

  localparam int REQ_W = $bits(cell_req_t);

  typedef struct packed {
    logic               accepted;
    logic [2:0]         layer;
    logic [6:0]         eta_bin;
    logic [3:0]         phi_bin;
    logic signed [23:0] value;
    logic               saturated;
    logic               zero_energy;
  } bin_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [79:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [14:0] cfg_data = '0;

  cell_energy_image_binner dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // model state
  logic signed [23:0] image_model [STORE_DEPTH];
  logic signed [15:0] centre_eta_m, centre_phi_m;
  logic signed [23:0] cluster_e_m;
  logic [14:0]        eta_win_m, phi_win_m;

  cell_req_t   pending_reqs [$];
  bin_result_t expected_bins [$];
  cell_req_t   held_req;
  int errors = 0;
  int n_added = 0, n_rejected = 0, n_sat = 0, n_zero = 0, n_reads = 0, n_clusters = 0;
  logic long_hold_req = 1'b0;

  function automatic void add_req(input cell_req_t q);
    pending_reqs = {pending_reqs, q};
  endfunction

  function automatic longint bin_index(longint d, logic [14:0] win, int n);
    longint w, num, b;
    w = (win == 0) ? 1 : longint'(win);
    num = 2 * d + w;
    if (num < 0) return -1;
    b = (num * n) / (2 * w);
    if (b >= n) return -1;
    return b;
  endfunction

  function automatic longint fraction_q16(longint num, longint den);
    longint un, ud, q;
    un = (num < 0) ? -num : num;
    ud = (den < 0) ? -den : den;
    q = (un + ud / 2) / ud;
    return ((num < 0) != (den < 0)) ? -q : q;
  endfunction

  task automatic bin_cell(input cell_req_t rq, output bin_result_t r);
    int lay, ne, np, idx;
    longint be, bp, s;
    r = '0;
    lay = -1;
    case (rq.mode)
      MODE_START: begin
        centre_eta_m = rq.eta;
        centre_phi_m = rq.phi;
        cluster_e_m = rq.energy;
        for (int i = 0; i < STORE_DEPTH; i++) image_model[i] = '0;
        n_clusters++;
      end
      MODE_CELL: begin
        for (int i = N_LAYERS - 1; i >= 0; i--)
          if (LAYER_CODE[i] == rq.code) lay = i;
        if (lay >= 0) begin
          ne = 1 << ETA_LOG[lay];
          np = 1 << PHI_LOG[lay];
          be = bin_index(longint'(rq.eta) - longint'(centre_eta_m), eta_win_m, ne);
          bp = bin_index(longint'(rq.phi) - longint'(centre_phi_m), phi_win_m, np);
        end
        if (lay < 0 || be < 0 || bp < 0) begin
          n_rejected++;
        end else begin
          idx = int'(LAYER_BASE[lay]) + int'(be) * np + int'(bp);
          r.layer = 3'(lay);
          r.eta_bin = 7'(be);
          r.phi_bin = 4'(bp);
          if (cluster_e_m == 0) begin
            r.value = image_model[idx];
            r.zero_energy = 1'b1;
            n_zero++;
          end else begin
            s = longint'(image_model[idx]) +
                fraction_q16(longint'(rq.energy) * 65536, longint'(cluster_e_m));
            if (s > 8388607) begin
              s = 8388607;
              r.saturated = 1'b1;
            end else if (s < -8388608) begin
              s = -8388608;
              r.saturated = 1'b1;
            end
            if (r.saturated) n_sat++;
            image_model[idx] = 24'(s);
            r.accepted = 1'b1;
            r.value = 24'(s);
            n_added++;
          end
        end
      end
      MODE_READ: begin
        if (rq.rlayer < N_LAYERS) begin
          ne = 1 << ETA_LOG[rq.rlayer];
          np = 1 << PHI_LOG[rq.rlayer];
          if (rq.reta < ne && rq.rphi < np) begin
            idx = int'(LAYER_BASE[rq.rlayer]) + int'(rq.reta) * np + int'(rq.rphi);
            r.layer = rq.rlayer;
            r.eta_bin = rq.reta;
            r.phi_bin = rq.rphi;
            r.value = image_model[idx];
            n_reads++;
          end
        end
      end
      default: ;
    endcase
  endtask

  // sender: bursts with random gaps
  int burst_left = 4, gap_left = 0;
  always @(posedge clk) begin
    bin_result_t r;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        bin_cell(held_req, r);
        expected_bins = {expected_bins, r};
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          held_req = pending_reqs.pop_front();
          s_tuser <= held_req.mode;
          s_tdata <= {4'b0, held_req.rphi, held_req.reta, held_req.rlayer, held_req.energy,
                      held_req.phi, held_req.eta, held_req.code};
          s_tvalid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: its own stall pattern, plus one long hold-off on request
  int ready_run = 0, long_hold_left = 0;
  logic ready_phase = 1'b1, long_done = 1'b0;
  always @(posedge clk) begin
    if (long_hold_req && !long_done) begin
      long_done <= 1'b1;
      long_hold_left = 4000;
    end
    if (long_hold_left > 0) begin
      long_hold_left--;
      m_tready <= 1'b0;
    end else begin
      if (ready_run <= 0) begin
        ready_phase = ~ready_phase;
        ready_run = ready_phase ? $urandom_range(1, 40) : $urandom_range(1, 6);
      end
      ready_run--;
      m_tready <= ready_phase ? ($urandom_range(0, 7) != 0) : 1'b0;
    end
  end

  // monitor
  always @(posedge clk) begin
    bin_result_t want, got;
    if (!rst && m_tvalid && m_tready) begin
      got.accepted = m_tuser[0];
      got.saturated = m_tuser[1];
      got.zero_energy = m_tuser[2];
      got.layer = m_tdata[2:0];
      got.eta_bin = m_tdata[9:3];
      got.phi_bin = m_tdata[13:10];
      got.value = m_tdata[37:14];
      if (expected_bins.size() == 0) begin
        $error("result with no request pending: %p", got);
        errors++;
      end else begin
        want = expected_bins.pop_front();
        if (got.accepted != want.accepted) begin
          $error("accepted: expected %0d actual %0d", want.accepted, got.accepted); errors++;
        end
        if (got.layer != want.layer) begin
          $error("hit_layer: expected %0d actual %0d", want.layer, got.layer); errors++;
        end
        if (got.eta_bin != want.eta_bin) begin
          $error("hit_eta_bin: expected %0d actual %0d", want.eta_bin, got.eta_bin); errors++;
        end
        if (got.phi_bin != want.phi_bin) begin
          $error("hit_phi_bin: expected %0d actual %0d", want.phi_bin, got.phi_bin); errors++;
        end
        if (got.value != want.value) begin
          $error("bin_value: expected %0d actual %0d", want.value, got.value); errors++;
        end
        if (got.saturated != want.saturated) begin
          $error("saturated: expected %0d actual %0d", want.saturated, got.saturated); errors++;
        end
        if (got.zero_energy != want.zero_energy) begin
          $error("zero_energy: expected %0d actual %0d", want.zero_energy, got.zero_energy);
          errors++;
        end
      end
    end
  end

  function automatic cell_req_t mk(logic [1:0] m, int c, int e, int p, int en,
                                   int rl = 0, int re = 0, int rp = 0);
    cell_req_t q;
    q.mode = m; q.code = 6'(c); q.eta = 16'(e); q.phi = 16'(p); q.energy = 24'(en);
    q.rlayer = 3'(rl); q.reta = 7'(re); q.rphi = 4'(rp);
    return q;
  endfunction

  function automatic cell_req_t noise_req();
    cell_req_t q;
    q = REQ_W'({$urandom, $urandom, $urandom});
    if (q.mode == MODE_START && $urandom_range(0, 3) != 0) q.mode = MODE_IDLE;
    return q;
  endfunction

  function automatic int clamp16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return int'(v);
  endfunction

  task automatic write_reg(logic idx, logic [14:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == CFG_ETA_WINDOW) eta_win_m = val;
    else phi_win_m = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // nothing queued, nothing offered and every result taken
  task automatic wait_idle();
    wait (pending_reqs.size() == 0 && !s_tvalid && expected_bins.size() == 0);
    repeat (1100) @(posedge clk);
  endtask

  // one cluster: start, cells near the centre, read-backs, a little noise
  task automatic queue_cluster(input int n_items);
    int ce, cp, ce_en, lay, half_e, half_p, pick;
    ce = $signed($urandom_range(0, 40000)) - 20000;
    cp = $signed($urandom_range(0, 40000)) - 20000;
    pick = $urandom_range(0, 15);
    if (pick == 0) ce_en = 0;
    else if (pick == 1) ce_en = $signed($urandom_range(0, 1) ? 8388607 : -8388608);
    else if (pick < 4) ce_en = $signed($urandom_range(0, 20)) - 10;
    else ce_en = $signed($urandom_range(0, 200000)) - 50000;
    add_req(mk(MODE_START, $urandom, ce, cp, ce_en, $urandom, $urandom, $urandom));
    half_e = (eta_win_m == 0) ? 1 : int'(eta_win_m);
    half_p = (phi_win_m == 0) ? 1 : int'(phi_win_m);
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(0, 19);
      lay = $urandom_range(0, N_LAYERS - 1);
      if (pick < 13) begin
        add_req(mk(MODE_CELL, int'(LAYER_CODE[lay]),
          clamp16(ce + $signed($urandom_range(0, half_e * 6 / 5)) - half_e * 3 / 5),
          clamp16(cp + $signed($urandom_range(0, half_p * 6 / 5)) - half_p * 3 / 5),
          ($urandom_range(0, 9) == 0) ? $signed($urandom) >>> 8
                                      : $signed($urandom_range(0, 60000)) - 20000,
          $urandom, $urandom, $urandom));
      end else if (pick < 18) begin
        add_req(mk(MODE_READ, $urandom, $urandom, $urandom, $urandom, lay,
          $urandom_range(0, (1 << ETA_LOG[lay]) - 1),
          $urandom_range(0, (1 << PHI_LOG[lay]) - 1)));
      end else begin
        add_req(noise_req());
      end
    end
  endtask

  initial begin
    logic [14:0] eta_set [6];
    logic [14:0] phi_set [6];
    int budget;
    eta_set = '{15'd1, 15'd32767, 15'd0, 15'd4096, 15'd800, 15'd1638};
    phi_set = '{15'd1, 15'd32767, 15'd4096, 15'd1, 15'd3000, 15'd1638};
    for (int i = 0; i < STORE_DEPTH; i++) image_model[i] = '0;
    centre_eta_m = '0; centre_phi_m = '0; cluster_e_m = '0;
    eta_win_m = 15'd1638; phi_win_m = 15'd1638;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: zero cluster energy after reset, edges, layers, reads, saturation
    add_req(mk(MODE_CELL, 2, 0, 0, 500));
    add_req(mk(MODE_START, 0, 0, 0, 1000));
    for (int l = 0; l < N_LAYERS; l++)
      add_req(mk(MODE_CELL, int'(LAYER_CODE[l]), 0, 0, 1000));
    add_req(mk(MODE_CELL, 1, -819, -819, -3000));
    add_req(mk(MODE_CELL, 1, 818, 818, 7));
    add_req(mk(MODE_CELL, 1, 819, 0, 7));
    add_req(mk(MODE_CELL, 63, 0, 0, 100));
    add_req(mk(MODE_CELL, 1, -32768, 32767, 100));
    add_req(mk(MODE_IDLE, 63, -1, -1, -1, 7, 127, 15));
    add_req(mk(MODE_READ, 0, 0, 0, 0, 0, 64, 2));
    add_req(mk(MODE_READ, 0, 0, 0, 0, 6, 0, 0));
    add_req(mk(MODE_READ, 0, 0, 0, 0, 7, 127, 15));
    add_req(mk(MODE_READ, 0, 0, 0, 0, 5, 2, 0));
    add_req(mk(MODE_START, 63, 32767, -32768, 1));
    add_req(mk(MODE_CELL, 14, 32767, -32768, 8388607));
    add_req(mk(MODE_CELL, 14, 32767, -32768, -8388608));
    add_req(mk(MODE_CELL, 14, 32767, -32768, -8388608));
    add_req(mk(MODE_START, 0, 0, 0, -8388608));
    add_req(mk(MODE_CELL, 3, 0, 0, 8388607));
    add_req(mk(MODE_READ, 0, 0, 0, 0, 2, 4, 8));
    wait_idle();

    // random phases, one window setting each
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_ETA_WINDOW, eta_set[ph]);
      write_reg(CFG_PHI_WINDOW, phi_set[ph]);
      budget = 300;
      while (budget > 0) begin
        int n;
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(25, 50) : $urandom_range(4, 16);
        queue_cluster(n);
        budget -= n + 1;
        if (ph == 2 && budget < 150) long_hold_req = 1'b1;
        wait (pending_reqs.size() < 20);
      end
      wait_idle();
    end

    wait_idle();
    $display("covered %0d clusters, %0d cell adds (%0d clipped), %0d rejected cells",
             n_clusters, n_added, n_sat, n_rejected);
    $display("plus %0d zero-energy hits and %0d valid bin reads over 7 window settings",
             n_zero, n_reads);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
